@@ src/srsw_pkg.sv @@
// Shared constants, codes and handshake types for the send window unit.
package srsw_pkg;

  localparam int RING_SLOTS = 32;
  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int CNT_W = SLOT_W + 1;
  localparam int SEQ_W = 8;
  localparam int TIME_W = 32;
  localparam int TMO_W = 16;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] ST_SENT = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_ACK_TAKEN = 3'd2;
  localparam logic [2:0] ST_ACK_OOW = 3'd3;
  localparam logic [2:0] ST_RETX = 3'd4;
  localparam logic [2:0] ST_IDLE_TICK = 3'd5;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [CNT_W-1:0] WINDOW_RESET = 6'd31;

  typedef struct packed {
    logic take;
    logic rd;
    logic cmp;
    logic emit;
  } srsw_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic hit;
    logic more;
    logic out_free;
  } srsw_stat_t;

endpackage

@@ src/srsw_ctrl.sv @@
// Controller state machine that sequences item intake, the timeout scan and result hand-off.
module srsw_ctrl
  import srsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  srsw_stat_t stat,
  output srsw_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD = 2'd1;
  localparam logic [1:0] S_CMP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_nxt = stat.scan_needed ? S_RD : S_EMIT;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (!stat.hit && stat.more) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/srsw_dp.sv @@
// Datapath holding the window state, the send time memory, the scan and the result registers.
module srsw_dp
  import srsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  srsw_cmd_t         cmd,
  output srsw_stat_t        stat,
  input  logic [1:0]        in_func,
  input  logic [SEQ_W-1:0]  in_ack_seq,
  input  logic              in_is_last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TMO_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [SEQ_W-1:0]  out_seq_out,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [CNT_W-1:0]  out_outstanding,
  output logic [SEQ_W-1:0]  out_oldest_unacked,
  output logic              out_done_res
);

  logic [TIME_W-1:0] time_mem [RING_SLOTS];
  logic [TIME_W-1:0] q_r;

  logic [SLOT_W-1:0] wpos_r;
  logic [CNT_W-1:0]  fill_r;
  logic [SEQ_W-1:0]  nseq_r;
  logic [SEQ_W-1:0]  oldest_r;
  logic [TIME_W-1:0] now_r;
  logic              lastf_r;
  logic [SLOT_W-1:0] lasts_r;
  logic [TMO_W-1:0]  tmo_r;
  logic [CNT_W-1:0]  lim_r;
  logic [SLOT_W-1:0] scan_r;
  logic [2:0]        pst_r;
  logic [SEQ_W-1:0]  pseq_r;
  logic [SLOT_W-1:0] pslot_r;
  logic              ovalid_r;
  logic [2:0]        ost_r;
  logic [SEQ_W-1:0]  oseq_r;
  logic [SLOT_W-1:0] oslot_r;
  logic [CNT_W-1:0]  ofill_r;
  logic [SEQ_W-1:0]  oold_r;
  logic              odone_r;

  logic [SLOT_W-1:0] base;
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] last_dist;
  logic [CNT_W-1:0]  eff_lim;
  logic [SEQ_W-1:0]  ack_k;
  logic              ack_ok;
  logic [TIME_W-1:0] age;
  logic              hit;
  logic              send_ok;
  logic              done;

  assign base = wpos_r - fill_r[SLOT_W-1:0];
  assign scan_addr = base + scan_r;
  assign last_dist = lasts_r - base;
  assign done = lastf_r && !({1'b0, last_dist} < fill_r);
  assign eff_lim = (lim_r == '0) ? CNT_W'(1) :
                   (lim_r > CNT_W'(RING_SLOTS)) ? CNT_W'(RING_SLOTS) : lim_r;
  assign send_ok = fill_r < eff_lim;
  assign ack_k = in_ack_seq - oldest_r;
  assign ack_ok = (ack_k != '0) && (ack_k <= {{(SEQ_W-CNT_W){1'b0}}, fill_r});
  assign age = now_r - q_r;
  assign hit = age > {{(TIME_W-TMO_W){1'b0}}, tmo_r};

  assign stat.scan_needed = (in_func == FUNC_TICK) && (fill_r != '0);
  assign stat.hit = hit;
  assign stat.more = ({1'b0, scan_r} + CNT_W'(1)) < fill_r;
  assign stat.out_free = !ovalid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.take && in_func == FUNC_SEND && send_ok) begin
      time_mem[wpos_r] <= now_r;
    end else if (cmd.cmp && hit) begin
      time_mem[scan_addr] <= now_r;
    end
    if (cmd.rd) begin
      q_r <= time_mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      unique case (in_func)
        FUNC_SEND: begin
          pst_r <= send_ok ? ST_SENT : ST_FULL;
          pseq_r <= send_ok ? nseq_r : '0;
          pslot_r <= send_ok ? wpos_r : '0;
        end
        FUNC_ACK: begin
          pst_r <= ack_ok ? ST_ACK_TAKEN : ST_ACK_OOW;
          pseq_r <= '0;
          pslot_r <= '0;
        end
        default: begin
          pst_r <= ST_IDLE_TICK;
          pseq_r <= '0;
          pslot_r <= '0;
        end
      endcase
      scan_r <= '0;
    end else if (cmd.cmp) begin
      if (hit) begin
        pst_r <= ST_RETX;
        pseq_r <= oldest_r + {{(SEQ_W-SLOT_W){1'b0}}, scan_r};
        pslot_r <= scan_addr;
      end else begin
        scan_r <= scan_r + SLOT_W'(1);
      end
    end
    if (cmd.emit) begin
      ost_r <= pst_r;
      oseq_r <= pseq_r;
      oslot_r <= pslot_r;
      ofill_r <= fill_r;
      oold_r <= oldest_r;
      odone_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      fill_r <= '0;
      nseq_r <= '0;
      oldest_r <= '0;
      now_r <= '0;
      lastf_r <= 1'b0;
      lasts_r <= '0;
      tmo_r <= TIMEOUT_RESET;
      lim_r <= WINDOW_RESET;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: tmo_r <= cfg_data;
          CFG_WINDOW: lim_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        unique case (in_func)
          FUNC_SEND: begin
            if (send_ok) begin
              wpos_r <= wpos_r + SLOT_W'(1);
              fill_r <= fill_r + CNT_W'(1);
              nseq_r <= nseq_r + SEQ_W'(1);
              if (in_is_last) begin
                lastf_r <= 1'b1;
                lasts_r <= wpos_r;
              end
            end
          end
          FUNC_ACK: begin
            if (ack_ok) begin
              fill_r <= fill_r - ack_k[CNT_W-1:0];
              oldest_r <= in_ack_seq;
            end
          end
          FUNC_TICK: now_r <= now_r + TIME_W'(1);
          default: ;
        endcase
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_status = ost_r;
  assign out_seq_out = oseq_r;
  assign out_slot_out = oslot_r;
  assign out_outstanding = ofill_r;
  assign out_oldest_unacked = oold_r;
  assign out_done_res = odone_r;

endmodule

@@ src/selective_repeat_send_window_unit.sv @@
// Sender window for a cumulative-ack ARQ link: send, ack and tick items in, one result item out.
// A send or ack item goes from the idle state straight to the emit state; a tick with packets in flight
// first runs the timeout scan, which reads the send time memory one slot at a time (a read state
// then a compare state), oldest first, and stops at the first expired packet. Input
// is taken only in the idle state, but a finished result may still wait on out_stall meanwhile.
module selective_repeat_send_window_unit
  import srsw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [SEQ_W-1:0]  in_ack_seq,
  input  logic              in_is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [SEQ_W-1:0]  out_seq_out,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [CNT_W-1:0]  out_outstanding,
  output logic [SEQ_W-1:0]  out_oldest_unacked,
  output logic              out_done_res,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TMO_W-1:0]  cfg_data
);

  srsw_cmd_t  cmd;
  srsw_stat_t stat;

  srsw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  srsw_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_func(in_func), .in_ack_seq(in_ack_seq), .in_is_last(in_is_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_seq_out(out_seq_out), .out_slot_out(out_slot_out),
    .out_outstanding(out_outstanding), .out_oldest_unacked(out_oldest_unacked),
    .out_done_res(out_done_res)
  );

endmodule

@@ src/srsw_checker.sv @@
// Port-level checker for the send window unit and its bind.
module srsw_checker
  import srsw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_status,
  input logic [SEQ_W-1:0]  out_seq_out,
  input logic [SLOT_W-1:0] out_slot_out,
  input logic [CNT_W-1:0]  out_outstanding
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_seq_out))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_outstanding <= CNT_W'(RING_SLOTS))
    else $error("outstanding count beyond ring size");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_ACK_TAKEN ||
    out_status == ST_ACK_OOW || out_status == ST_IDLE_TICK)
    |-> out_seq_out == '0 && out_slot_out == '0)
    else $error("seq or slot nonzero on a non-send result");

  a_retx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RETX |-> out_outstanding != '0)
    else $error("retransmit with nothing in flight");

endmodule

bind selective_repeat_send_window_unit srsw_checker u_srsw_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_seq_out(out_seq_out), .out_slot_out(out_slot_out),
  .out_outstanding(out_outstanding)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the selective repeat send window unit.
`timescale 1ns / 100ps

module tb_top;
  import srsw_pkg::*;

  localparam int CLK_HI = 6;
  localparam int CLK_LO = 6;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CALM_ITEMS = 200;

  typedef struct packed {
    logic [2:0]        status;
    logic [SEQ_W-1:0]  seq;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  outstanding;
    logic [SEQ_W-1:0]  oldest;
    logic              done;
  } window_result_t;

  typedef struct {
    logic [1:0]       func;
    logic [SEQ_W-1:0] ack;
    logic             last;
    bit               typed;
    window_result_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [SEQ_W-1:0] in_ack_seq = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [SEQ_W-1:0] out_seq_out;
  logic [SLOT_W-1:0] out_slot_out;
  logic [CNT_W-1:0] out_outstanding;
  logic [SEQ_W-1:0] out_oldest_unacked;
  logic out_done_res;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_TIMEOUT;
  logic [TMO_W-1:0] cfg_data = '0;

  selective_repeat_send_window_unit dut (.*);

  always begin
    #CLK_HI clk = 1'b0;
    #CLK_LO clk = 1'b1;
  end

  // Window state mirror.
  logic [TMO_W-1:0]  w_timeout;
  logic [CNT_W-1:0]  w_limit;
  logic [SEQ_W-1:0]  w_seq [RING_SLOTS];
  logic              w_acked [RING_SLOTS];
  logic [TIME_W-1:0] w_stamp [RING_SLOTS];
  logic [SLOT_W-1:0] w_wpos;
  int                w_fill;
  logic [SEQ_W-1:0]  w_next;
  logic [SEQ_W-1:0]  w_oldest;
  logic [TIME_W-1:0] w_now;
  logic              w_last_flag;
  logic [SLOT_W-1:0] w_last_slot;

  window_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int retx_seen = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  task automatic mirror_reset();
    w_timeout = TIMEOUT_RESET;
    w_limit = WINDOW_RESET;
    for (int i = 0; i < RING_SLOTS; i++) begin
      w_seq[i] = '1;
      w_acked[i] = 1'b1;
      w_stamp[i] = '0;
    end
    w_wpos = '0;
    w_fill = 0;
    w_next = '0;
    w_oldest = '0;
    w_now = '0;
    w_last_flag = 1'b0;
    w_last_slot = '0;
  endtask

  function automatic window_result_t window_step(logic [1:0] func, logic [SEQ_W-1:0] ack,
                                                 logic last);
    window_result_t r;
    int lim;
    int k;
    logic [SLOT_W-1:0] s;
    r = '0;
    r.status = ST_IDLE_TICK;
    lim = (w_limit == 0) ? 1 : int'(w_limit);
    if (lim > RING_SLOTS) lim = RING_SLOTS;
    if (func == FUNC_SEND) begin
      if (w_fill >= lim) begin
        r.status = ST_FULL;
      end else begin
        s = w_wpos;
        w_seq[s] = w_next;
        w_acked[s] = 1'b0;
        w_stamp[s] = w_now;
        if (last) begin
          w_last_flag = 1'b1;
          w_last_slot = s;
        end
        r.status = ST_SENT;
        r.seq = w_next;
        r.slot = s;
        w_wpos = s + 1'b1;
        w_fill++;
        w_next = w_next + 1'b1;
      end
    end else if (func == FUNC_ACK) begin
      k = int'(8'(ack - w_oldest));
      if (k >= 1 && k <= w_fill) begin
        for (int i = 0; i < k; i++) w_acked[SLOT_W'(w_wpos - w_fill + i)] = 1'b1;
        w_fill -= k;
        w_oldest = ack;
        r.status = ST_ACK_TAKEN;
      end else begin
        r.status = ST_ACK_OOW;
      end
    end else if (func == FUNC_TICK) begin
      w_now = w_now + 1;
      for (int i = 0; i < w_fill; i++) begin
        s = SLOT_W'(w_wpos - w_fill + i);
        if (!w_acked[s] && (w_now - w_stamp[s]) > TIME_W'(w_timeout)) begin
          r.status = ST_RETX;
          r.seq = w_seq[s];
          r.slot = s;
          w_stamp[s] = w_now;
          break;
        end
      end
    end
    r.outstanding = CNT_W'(w_fill);
    r.oldest = w_oldest;
    r.done = w_last_flag && w_acked[w_last_slot];
    return r;
  endfunction

  task automatic send_item(logic [1:0] func, logic [SEQ_W-1:0] ack, logic last);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_ack_seq <= ack;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic apply_item(logic [1:0] func, logic [SEQ_W-1:0] ack, logic last);
    expected_q.push_back(window_step(func, ack, last));
    send_item(func, ack, last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TMO_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    if (idx == CFG_TIMEOUT) w_timeout = val;
    else w_limit = CNT_W'(val);
  endtask

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end
  end

  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_seq_out, out_slot_out, out_outstanding, out_oldest_unacked,
             out_done_res};
      results_seen <= results_seen + 1;
      if (got.status == ST_RETX) retx_seen <= retx_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors <= errors + 1;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d seq=%0d slot=%0d out=%0d old=%0d done=%0d",
                   $realtime, want.status, want.seq, want.slot, want.outstanding, want.oldest,
                   want.done);
          $display("%0t:          actual st=%0d seq=%0d slot=%0d out=%0d old=%0d done=%0d",
                   $realtime, got.status, got.seq, got.slot, got.outstanding, got.oldest,
                   got.done);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  stim_row_t rows[$];

  function automatic stim_row_t row(logic [1:0] f, logic [SEQ_W-1:0] a, logic l, bit t,
                                    window_result_t r);
    stim_row_t x;
    x.func = f;
    x.ack = a;
    x.last = l;
    x.typed = t;
    x.res = r;
    return x;
  endfunction

  initial begin
    window_result_t pred;
    logic [1:0] f;
    logic [SEQ_W-1:0] a;
    int burst;
    mirror_reset();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back(row(FUNC_TICK, 8'h00, 1'b0, 1, {ST_IDLE_TICK, 8'd0, 5'd0, 6'd0, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'h00, 1'b0, 1, {ST_ACK_OOW, 8'd0, 5'd0, 6'd0, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'hFF, 1'b1, 1, {ST_ACK_OOW, 8'd0, 5'd0, 6'd0, 8'd0, 1'b0}));
    rows.push_back(row(2'd3, 8'hAA, 1'b1, 1, {ST_IDLE_TICK, 8'd0, 5'd0, 6'd0, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_SEND, 8'h55, 1'b0, 1, {ST_SENT, 8'd0, 5'd0, 6'd1, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_SEND, 8'h00, 1'b1, 1, {ST_SENT, 8'd1, 5'd1, 6'd2, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'h00, 1'b0, 1, {ST_ACK_OOW, 8'd0, 5'd0, 6'd2, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'h03, 1'b0, 1, {ST_ACK_OOW, 8'd0, 5'd0, 6'd2, 8'd0, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'h01, 1'b0, 1, {ST_ACK_TAKEN, 8'd0, 5'd0, 6'd1, 8'd1, 1'b0}));
    rows.push_back(row(FUNC_ACK, 8'h02, 1'b0, 1, {ST_ACK_TAKEN, 8'd0, 5'd0, 6'd0, 8'd2, 1'b1}));
    rows.push_back(row(FUNC_SEND, 8'h00, 1'b0, 0, '0));
    for (int i = 0; i < 12; i++) rows.push_back(row(FUNC_TICK, 8'h00, 1'b0, 0, '0));
    foreach (rows[i]) begin
      pred = window_step(rows[i].func, rows[i].ack, rows[i].last);
      expected_q.push_back(rows[i].typed ? rows[i].res : pred);
      send_item(rows[i].func, rows[i].ack, rows[i].last);
    end
    drain();

    // Phases over window and timeout settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TIMEOUT, 16'd1); write_reg(CFG_WINDOW, 16'd1); end
        1: begin write_reg(CFG_TIMEOUT, 16'd3); write_reg(CFG_WINDOW, 16'd32); end
        2: begin write_reg(CFG_TIMEOUT, 16'hFFFF); write_reg(CFG_WINDOW, 16'd63); end
        3: begin write_reg(CFG_TIMEOUT, 16'd5); write_reg(CFG_WINDOW, 16'd0); end
        default: begin
          write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
          write_reg(CFG_WINDOW, 16'($urandom_range(1, 63)));
        end
      endcase
      cfg_we <= 1'b0;
      if (ph == 7) calm = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
        burst = $urandom_range(0, 99);
        if (burst < 40) f = FUNC_SEND;
        else if (burst < 60) f = FUNC_ACK;
        else if (burst < 98) f = FUNC_TICK;
        else f = 2'd3;
        if (f == FUNC_ACK && $urandom_range(0, 4) != 0)
          a = w_oldest + SEQ_W'($urandom_range(0, w_fill + 1));
        else
          a = SEQ_W'($urandom);
        apply_item(f, a, ($urandom_range(0, 15) == 0));
      end
      drain();
    end

    $display("Covered %0d results, %0d retransmits, across eight window and timeout settings.",
             results_seen, retx_seen);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
